// File: hw/rtl/assert_macros.svh
// Assertion helpers. Every use expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/drhp_pkg.sv
package drhp_pkg;

  localparam int MAX_TEXT_LEN = 4096;
  localparam int POS_W        = $clog2(MAX_TEXT_LEN + 1);

  localparam logic [POS_W-1:0] POS_MAX        = POS_W'(MAX_TEXT_LEN);
  localparam logic [POS_W-1:0] POS_VER_START  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_VER_LAST   = POS_W'(9);
  localparam logic [POS_W-1:0] POS_VER_END    = POS_W'(10);
  localparam logic [POS_W-1:0] POS_HASH_START = POS_W'(14);
  localparam logic [POS_W-1:0] V1_FULL_LEN    = POS_W'(142);
  localparam logic [POS_W-1:0] V1_MIN_LEN     = POS_W'(78);
  localparam logic [POS_W-1:0] MIN_DOC_LEN    = POS_W'(42);

  localparam int HDR_LEN = 6;
  localparam logic [8*HDR_LEN-1:0] HDR_TEXT  = "444D24";
  localparam logic [31:0]          VER1_TEXT = "0001";
  localparam logic [31:0]          VER2_TEXT = "0002";

  localparam logic [7:0] CHAR_0       = "0";
  localparam logic [7:0] CHAR_9       = "9";
  localparam logic [7:0] CHAR_F       = "F";
  localparam logic [7:0] CHAR_A       = "A";
  localparam logic [7:0] CHAR_B       = "B";
  localparam logic [7:0] CHAR_LOWER_A = "a";
  localparam logic [7:0] CHAR_LOWER_Z = "z";
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [4:0] MAX_RECORDS_RESET = 5'd19;

  localparam logic       KIND_DIGIT  = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;

  localparam logic [2:0] SLOT_GUID  = 3'd0;
  localparam logic [2:0] SLOT_INDEX = 3'd1;
  localparam logic [2:0] SLOT_FILE  = 3'd2;
  localparam logic [2:0] SLOT_ATTR  = 3'd3;
  localparam logic [2:0] SLOT_OWNER = 3'd4;

  localparam logic [1:0] STATUS_VALID     = 2'd0;
  localparam logic [1:0] STATUS_NOT_DOC   = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  localparam logic [1:0] VER_UNKNOWN = 2'd0;
  localparam logic [1:0] VER_1       = 2'd1;
  localparam logic [1:0] VER_2       = 2'd2;

  // APB: one register slot of 4 bytes, bit 2 selects the register index.
  localparam int   APB_ADDR_W      = 3;
  localparam logic REG_MAX_RECORDS = 1'b0;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
  localparam logic [OUTQ_CW-1:0] OUTQ_ROOM_MAX = OUTQ_CW'(OUTQ_DEPTH - 2);

  typedef enum logic [4:0] {
    PH_TYPE  = 5'b00001,
    PH_SEP   = 5'b00010,
    PH_ALGO1 = 5'b00100,
    PH_ALGO2 = 5'b01000,
    PH_HASH  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] slot;
    logic [6:0] hash_algo;
    logic [6:0] digit_index;
    logic [7:0] digit_char;
    logic       record_start;
    logic [1:0] status;
    logic [1:0] doc_version;
    logic       owner_present;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    dig_valid;
    result_t dig;
    logic    stat_valid;
    result_t stat;
  } push_t;

  typedef struct packed {
    logic [OUTQ_CW-1:0] count;
    logic               not_empty;
    logic               room2;
  } outq_status_t;

  function automatic logic [7:0] hash_len(input logic [6:0] algo);
    logic [7:0] len;
    unique case (algo)
      7'd0:          len = 8'd32;
      7'd1:          len = 8'd40;
      7'd21, 7'd31:  len = 8'd56;
      7'd22, 7'd32:  len = 8'd64;
      7'd23, 7'd33:  len = 8'd96;
      7'd25, 7'd35:  len = 8'd128;
      default:       len = 8'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    return HDR_TEXT[(HDR_LEN - 1 - int'(idx)) * 8 +: 8];
  endfunction

  function automatic logic [2:0] v1_slot(input logic [1:0] quarter);
    logic [2:0] s;
    unique case (quarter)
      2'd0: s = SLOT_GUID;
      2'd1: s = SLOT_FILE;
      2'd2: s = SLOT_ATTR;
      2'd3: s = SLOT_OWNER;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/drhp_in_if.sv
interface drhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, ch, end_of_text, input ready);
  modport sink (input valid, ch, end_of_text, output ready);
endinterface

// File: hw/rtl/drhp_out_if.sv
interface drhp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] slot;
  logic [6:0] hash_algo;
  logic [6:0] digit_index;
  logic [7:0] digit_char;
  logic       record_start;
  logic [1:0] status;
  logic [1:0] doc_version;
  logic       owner_present;
  logic       last;

  modport source (output valid, kind, slot, hash_algo, digit_index, digit_char,
                  record_start, status, doc_version, owner_present, last,
                  input ready);
  modport sink (input valid, kind, slot, hash_algo, digit_index, digit_char,
                record_start, status, doc_version, owner_present, last,
                output ready);
endinterface

// File: hw/rtl/drhp_core.sv
module drhp_core import drhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] ch,
  input  logic       end_of_text,
  input  logic [4:0] max_records,
  output push_t      push
);

  logic [POS_W-1:0] position, position_next;
  logic             header_ok, header_ok_next;
  logic [1:0]       version_code, version_code_next;
  logic [31:0]      version_chars, version_chars_next;
  phase_t           phase, phase_next;
  logic [7:0]       record_type, record_type_next;
  logic [6:0]       algo_value, algo_value_next;
  logic [7:0]       digits_left, digits_left_next;
  logic [6:0]       digit_count, digit_count_next;
  logic [4:0]       record_count, record_count_next;
  logic             error_flag, error_flag_next;

  always_comb begin
    logic [7:0]       c;
    logic [POS_W-1:0] off;
    logic             is_dec;
    logic [6:0]       algo_mix;
    logic [7:0]       hlen;
    logic [7:0]       dl;
    logic [2:0]       slot;
    logic             slot_ok;
    logic [31:0]      vc;
    logic             err;

    position_next      = position;
    header_ok_next     = header_ok;
    version_code_next  = version_code;
    version_chars_next = version_chars;
    phase_next         = phase;
    record_type_next   = record_type;
    algo_value_next    = algo_value;
    digits_left_next   = digits_left;
    digit_count_next   = digit_count;
    record_count_next  = record_count;
    error_flag_next    = error_flag;
    push               = '0;

    c = (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ? ch - CASE_OFFSET : ch;
    off      = position - POS_HASH_START;
    is_dec   = (c >= CHAR_0) && (c <= CHAR_9);
    algo_mix = 7'({algo_value, 3'b000} + {algo_value, 1'b0} + {3'b000, c[3:0]});
    hlen     = hash_len(algo_mix);
    dl       = (digits_left != 8'd0) ? digits_left - 8'd1 : 8'd0;
    vc       = {version_chars[23:0], c};
    slot     = SLOT_GUID;
    slot_ok  = 1'b0;
    err      = 1'b0;

    if (record_type == CHAR_0) begin
      slot = SLOT_GUID;  slot_ok = 1'b1;
    end else if (record_type == CHAR_F) begin
      slot = (algo_value == 7'd0) ? SLOT_INDEX : SLOT_FILE;  slot_ok = 1'b1;
    end else if (record_type == CHAR_A) begin
      slot = SLOT_ATTR;  slot_ok = 1'b1;
    end else if (record_type == CHAR_B) begin
      slot = SLOT_OWNER; slot_ok = 1'b1;
    end

    if (position >= POS_MAX) begin
      // Overlong text: the position saturates and the character is dropped.
      error_flag_next = 1'b1;
    end else begin
      position_next = position + POS_W'(1);
      if (position < POS_VER_START) begin
        if (c != hdr_char(position[2:0])) header_ok_next = 1'b0;
      end else if (position < POS_VER_END) begin
        version_chars_next = vc;
        if (position == POS_VER_LAST) begin
          if (vc == VER1_TEXT) version_code_next = VER_1;
          else if (vc == VER2_TEXT) version_code_next = VER_2;
        end
      end else if (position >= POS_HASH_START && header_ok && !error_flag) begin
        if (version_code == VER_1) begin
          if (position < V1_FULL_LEN) begin
            push.dig_valid        = 1'b1;
            push.dig.kind         = KIND_DIGIT;
            push.dig.slot         = v1_slot(off[6:5]);
            push.dig.digit_index  = {2'b00, off[4:0]};
            push.dig.digit_char   = c;
            push.dig.record_start = (off[4:0] == 5'd0);
            push.dig.doc_version  = VER_1;
          end
        end else if (version_code == VER_2) begin
          unique case (phase)
            PH_TYPE: begin
              if (record_count >= max_records) begin
                error_flag_next = 1'b1;
              end else begin
                record_count_next = record_count + 5'd1;
                record_type_next  = c;
                phase_next        = PH_SEP;
              end
            end
            PH_SEP: begin
              phase_next = PH_ALGO1;
            end
            PH_ALGO1: begin
              if (!is_dec) begin
                error_flag_next = 1'b1;
              end else begin
                algo_value_next = {3'b000, c[3:0]};
                phase_next      = PH_ALGO2;
              end
            end
            PH_ALGO2: begin
              if (!is_dec) begin
                error_flag_next = 1'b1;
              end else begin
                algo_value_next  = algo_mix;
                digits_left_next = hlen;
                digit_count_next = 7'd0;
                phase_next       = (hlen != 8'd0) ? PH_HASH : PH_TYPE;
              end
            end
            PH_HASH: begin
              if (slot_ok) begin
                push.dig_valid        = 1'b1;
                push.dig.kind         = KIND_DIGIT;
                push.dig.slot         = slot;
                push.dig.hash_algo    = algo_value;
                push.dig.digit_index  = digit_count;
                push.dig.digit_char   = c;
                push.dig.record_start = (digit_count == 7'd0);
                push.dig.doc_version  = VER_2;
              end
              digit_count_next = digit_count + 7'd1;
              digits_left_next = dl;
              if (dl == 8'd0) phase_next = PH_TYPE;
            end
            default: begin
              phase_next = PH_TYPE;
            end
          endcase
        end
      end
    end

    push.dig.last = !end_of_text;

    if (end_of_text) begin
      err = error_flag_next;
      if (header_ok_next && position_next >= MIN_DOC_LEN) begin
        if (version_code_next == VER_1 && position_next < V1_MIN_LEN) err = 1'b1;
        if (version_code_next == VER_2 &&
            (phase_next == PH_SEP || phase_next == PH_ALGO1 || phase_next == PH_ALGO2))
          err = 1'b1;
      end
      push.stat_valid = 1'b1;
      push.stat.kind  = KIND_STATUS;
      push.stat.last  = 1'b1;
      if (position_next < MIN_DOC_LEN || !header_ok_next) begin
        push.stat.status = STATUS_NOT_DOC;
      end else if (err) begin
        push.stat.status = STATUS_MALFORMED;
      end else begin
        push.stat.status        = STATUS_VALID;
        push.stat.doc_version   = version_code_next;
        push.stat.owner_present = (version_code_next == VER_1) &&
                                  (position_next == V1_FULL_LEN);
      end

      // The next character starts a fresh text.
      position_next      = '0;
      header_ok_next     = 1'b1;
      version_code_next  = VER_UNKNOWN;
      version_chars_next = '0;
      phase_next         = PH_TYPE;
      record_type_next   = '0;
      algo_value_next    = '0;
      digits_left_next   = '0;
      digit_count_next   = '0;
      record_count_next  = '0;
      error_flag_next    = 1'b0;
    end

    if (!fire) begin
      push.dig_valid  = 1'b0;
      push.stat_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      header_ok     <= 1'b1;
      version_code  <= VER_UNKNOWN;
      version_chars <= '0;
      phase         <= PH_TYPE;
      record_type   <= '0;
      algo_value    <= '0;
      digits_left   <= '0;
      digit_count   <= '0;
      record_count  <= '0;
      error_flag    <= 1'b0;
    end else if (fire) begin
      position      <= position_next;
      header_ok     <= header_ok_next;
      version_code  <= version_code_next;
      version_chars <= version_chars_next;
      phase         <= phase_next;
      record_type   <= record_type_next;
      algo_value    <= algo_value_next;
      digits_left   <= digits_left_next;
      digit_count   <= digit_count_next;
      record_count  <= record_count_next;
      error_flag    <= error_flag_next;
    end
  end

endmodule

// File: hw/rtl/drhp_outq.sv
module drhp_outq import drhp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  input  logic         pop,
  output result_t      head,
  output outq_status_t status
);

  result_t            entries [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr, wr_ptr_next;
  logic [OUTQ_AW-1:0] rd_ptr, rd_ptr_next;
  logic [OUTQ_CW-1:0] count, count_next;
  logic [OUTQ_AW-1:0] stat_ptr;
  logic               do_pop;

  // A digit result goes in ahead of the status result of the same item.
  assign stat_ptr = wr_ptr + OUTQ_AW'(push.dig_valid);
  assign do_pop   = pop && (count != '0);

  always_comb begin
    wr_ptr_next = wr_ptr + OUTQ_AW'(push.dig_valid) + OUTQ_AW'(push.stat_valid);
    rd_ptr_next = rd_ptr + OUTQ_AW'(do_pop);
    count_next  = count + OUTQ_CW'(push.dig_valid) + OUTQ_CW'(push.stat_valid)
                  - OUTQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.dig_valid) entries[wr_ptr] <= push.dig;
    if (push.stat_valid) entries[stat_ptr] <= push.stat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  assign head             = entries[rd_ptr];
  assign status.count     = count;
  assign status.not_empty = (count != '0);
  assign status.room2     = (count <= OUTQ_ROOM_MAX);

endmodule

// File: hw/rtl/document_record_hex_parser.sv
// Document record hex parser.
// The chars channel takes the record text one character per item; end_of_text
// marks the final character. Each character that lands on a hash digit gives a
// digit item on the results channel, tagged with its slot and position; the
// final character also gives a status item (valid, not a document, malformed)
// with the version and owner flag, and the parser then starts a new text.
// Items from one character leave in order, the last one carrying last.
// Throughput: one character per cycle while each gives at most one result and
// the receiver keeps taking results. The four-entry result queue sets this:
// chars.ready is high while two entries are free, so input keeps flowing
// while a result waits to be taken. When the receiver stalls, the queue
// fills and chars.ready drops; nothing is lost. The APB register max_records
// (address 0, reset 19) bounds the number of version 2 records; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Reset (rst, synchronous) empties the queue and clears the
// parse state.
`include "assert_macros.svh"

module document_record_hex_parser import drhp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  drhp_in_if.sink               chars,
  drhp_out_if.source            results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic         max_reg_sel;
  logic [4:0]   max_records;
  logic         in_fire;
  push_t        push;
  result_t      head;
  outq_status_t q_status;
  logic         out_digit;
  logic         out_status;

  assign pready      = 1'b1;
  assign max_reg_sel = (paddr[APB_ADDR_W-1] == REG_MAX_RECORDS);
  assign prdata      = max_reg_sel ? {27'd0, max_records} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_records <= MAX_RECORDS_RESET;
    end else if (psel && penable && pwrite && pready && max_reg_sel) begin
      max_records <= pwdata[4:0];
    end
  end

  assign chars.ready = q_status.room2;
  assign in_fire     = chars.valid && chars.ready;

  drhp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .ch          (chars.ch),
    .end_of_text (chars.end_of_text),
    .max_records (max_records),
    .push        (push)
  );

  drhp_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (results.ready),
    .head   (head),
    .status (q_status)
  );

  assign results.valid         = q_status.not_empty;
  assign results.kind          = head.kind;
  assign results.slot          = head.slot;
  assign results.hash_algo     = head.hash_algo;
  assign results.digit_index   = head.digit_index;
  assign results.digit_char    = head.digit_char;
  assign results.record_start  = head.record_start;
  assign results.status        = head.status;
  assign results.doc_version   = head.doc_version;
  assign results.owner_present = head.owner_present;
  assign results.last          = head.last;

  assign out_digit  = results.valid && (results.kind == KIND_DIGIT);
  assign out_status = results.valid && (results.kind == KIND_STATUS);

  `ASSERT_NEXT(a_eot_gives_result, in_fire && chars.end_of_text, results.valid, "no status item")
  `ASSERT_ALWAYS(a_ready_has_room, !chars.ready || (q_status.count <= OUTQ_ROOM_MAX), "no room")
  `ASSERT_ALWAYS(a_status_is_last, !out_status || results.last, "status not last")
  `ASSERT_ALWAYS(a_digit_slot, !out_digit || (results.slot <= SLOT_OWNER), "bad slot")

endmodule
